// File: rtl/yuvds_pkg.sv
`timescale 1ns / 1ps
// shared constants and types for the 4:2:2 box downscaler
// no dependencies

package yuvds_pkg;

    localparam int CAMERA_WIDTH  = 1280;
    localparam int CAMERA_HEIGHT = 1024;

    localparam int MP_PER_ROW = CAMERA_WIDTH / 2;
    localparam int COL_W      = $clog2(MP_PER_ROW);
    localparam int ROW_W      = $clog2(CAMERA_HEIGHT / 2 + 1);
    localparam int SRC_ROW_W  = ROW_W + 2;

    localparam int LUMA_SUM_W   = 12;
    localparam int CHROMA_SUM_W = 11;
    localparam int SUM_W        = LUMA_SUM_W + 2 * CHROMA_SUM_W;

    localparam int OUT_ROWS_HALF    = CAMERA_HEIGHT / 2;
    localparam int OUT_ROWS_QUARTER = CAMERA_HEIGHT / 4;

    localparam logic MODE_HALF    = 1'b0;
    localparam logic MODE_QUARTER = 1'b1;

    // one item between the accept stage and the accumulate stage
    typedef struct packed {
        logic [COL_W-1:0] idx;
        logic             mode;
        logic             first;
        logic             emit;
        logic             row_end;
        logic             frame_end;
        logic [8:0]       luma_pair;
        logic [7:0]       chroma_a;
        logic [7:0]       chroma_b;
    } acc_item_t;

endpackage

// File: rtl/yuv422_box_downscaler.sv
`timescale 1ns / 1ps
// 4:2:2 box-filter downscaler, half or quarter in both dimensions
// depends on yuvds_pkg and yuvds_ram
//
// datapath: an item that completes its block is registered in s1_reg, and its result then in
// the output register that drives m_tdata
// throughput: one item per cycle while s_tready is high; the column accumulator ram is read at accept and
// written back from the accumulate stage, with a bypass when consecutive items hit one column
// s_tready drops only while an item that completes a block waits behind a result not yet taken
// reset: counters, scale mode and valids clear; the accumulator ram is not cleared

module yuv422_box_downscaler
    import yuvds_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic        cfg_wdata,     // scale_mode
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,       // chroma_a_in, luma_first_in, chroma_b_in, luma_second_in
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,       // luma_avg, chroma_a_avg, chroma_b_avg
    output logic        m_tuser,       // row_end
    output logic        m_tlast        // frame_end
);

    logic                 mode_reg;
    logic [COL_W-1:0]     col_reg, col_next;
    logic [1:0]           rib_reg, rib_next;
    logic [ROW_W-1:0]     orow_reg, orow_next;

    acc_item_t            s1_reg, s0_item;
    logic                 s1_valid_reg;
    logic                 fwd_reg;
    logic [SUM_W-1:0]     fwd_data_reg;

    logic                 m_valid_reg;
    logic [23:0]          m_data_reg;
    logic                 m_user_reg;
    logic                 m_last_reg;

    logic                 accept;
    logic                 s1_adv;
    logic                 s1_write;
    logic [SUM_W-1:0]     ram_rdata;
    logic [SUM_W-1:0]     old_sums;
    logic [SUM_W-1:0]     new_sums;
    logic [LUMA_SUM_W-1:0]   new_luma;
    logic [CHROMA_SUM_W-1:0] new_ca;
    logic [CHROMA_SUM_W-1:0] new_cb;
    logic [23:0]          s1_result;

    // accept-stage decode
    logic                 last_row;
    logic                 last_col;
    logic [ROW_W-1:0]     out_rows;
    logic [SRC_ROW_W-1:0] src_row;

    assign s1_adv   = !s1_valid_reg || !s1_reg.emit || !m_valid_reg || m_tready;
    assign s_tready = !s1_valid_reg || s1_adv;
    assign accept   = s_tvalid && s_tready;
    assign s1_write = s1_valid_reg && s1_adv;

    always_comb begin
        out_rows = (mode_reg == MODE_QUARTER) ? ROW_W'(OUT_ROWS_QUARTER)
                                              : ROW_W'(OUT_ROWS_HALF);
        last_row = (mode_reg == MODE_QUARTER) ? (rib_reg == 2'd3) : (rib_reg != 2'd0);
        last_col = (mode_reg == MODE_HALF) || col_reg[0];

        s0_item.mode      = mode_reg;
        s0_item.idx       = (mode_reg == MODE_QUARTER) ? (col_reg >> 1) : col_reg;
        s0_item.first     = (rib_reg == 2'd0) && ((mode_reg == MODE_HALF) || !col_reg[0]);
        s0_item.emit      = last_row && last_col && (orow_reg < out_rows);
        s0_item.row_end   = (mode_reg == MODE_QUARTER)
                          ? (s0_item.idx == COL_W'(MP_PER_ROW / 2 - 1))
                          : (s0_item.idx == COL_W'(MP_PER_ROW - 1));
        s0_item.frame_end = s0_item.row_end && (orow_reg == out_rows - ROW_W'(1));
        s0_item.luma_pair = {1'b0, s_tdata[15:8]} + {1'b0, s_tdata[31:24]};
        s0_item.chroma_a  = s_tdata[7:0];
        s0_item.chroma_b  = s_tdata[23:16];

        // source row index, from the output row and the row within its block of 2 or 4 rows
        src_row = (mode_reg == MODE_QUARTER)
                ? ({orow_reg, 2'b00} + SRC_ROW_W'(rib_reg))
                : ({1'b0, orow_reg, 1'b0} + SRC_ROW_W'(rib_reg));

        col_next  = col_reg;
        rib_next  = rib_reg;
        orow_next = orow_reg;
        if (col_reg >= COL_W'(MP_PER_ROW - 1)) begin
            col_next = '0;
            if (src_row >= SRC_ROW_W'(CAMERA_HEIGHT - 1)) begin
                rib_next  = '0;
                orow_next = '0;
            end else if (last_row) begin
                rib_next  = '0;
                orow_next = orow_reg + ROW_W'(1);
            end else begin
                rib_next = rib_reg + 2'd1;
            end
        end else begin
            col_next = col_reg + COL_W'(1);
        end
    end

    yuvds_ram #(
        .WIDTH (SUM_W),
        .DEPTH (MP_PER_ROW)
    ) u_sums_ram (
        .aclk  (aclk),
        .we    (s1_write),
        .waddr (s1_reg.idx),
        .wdata (new_sums),
        .re    (accept),
        .raddr (s0_item.idx),
        .rdata (ram_rdata)
    );

    // accumulate stage, bypassing a write to the same column made at read time
    always_comb begin
        old_sums = fwd_reg ? fwd_data_reg : ram_rdata;
        if (s1_reg.first) begin
            new_luma = LUMA_SUM_W'(s1_reg.luma_pair);
            new_ca   = CHROMA_SUM_W'(s1_reg.chroma_a);
            new_cb   = CHROMA_SUM_W'(s1_reg.chroma_b);
        end else begin
            new_luma = old_sums[SUM_W-1 -: LUMA_SUM_W] + LUMA_SUM_W'(s1_reg.luma_pair);
            new_ca   = old_sums[2*CHROMA_SUM_W-1 -: CHROMA_SUM_W]
                     + CHROMA_SUM_W'(s1_reg.chroma_a);
            new_cb   = old_sums[CHROMA_SUM_W-1:0] + CHROMA_SUM_W'(s1_reg.chroma_b);
        end
        new_sums = {new_luma, new_ca, new_cb};

        if (s1_reg.mode == MODE_QUARTER) begin
            s1_result = {new_cb[10:3], new_ca[10:3], new_luma[11:4]};
        end else begin
            s1_result = {new_cb[8:1], new_ca[8:1], new_luma[9:2]};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg     <= MODE_HALF;
            col_reg      <= '0;
            rib_reg      <= '0;
            orow_reg     <= '0;
            s1_valid_reg <= 1'b0;
            fwd_reg      <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (cfg_we) begin
                mode_reg <= cfg_wdata;
            end
            if (accept) begin
                col_reg  <= col_next;
                rib_reg  <= rib_next;
                orow_reg <= orow_next;
                fwd_reg  <= s1_write && (s1_reg.idx == s0_item.idx);
            end
            if (s_tready) begin
                s1_valid_reg <= accept;
            end
            if (s1_write && s1_reg.emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_reg       <= s0_item;
            fwd_data_reg <= new_sums;
        end
        if (s1_write && s1_reg.emit) begin
            m_data_reg <= s1_result;
            m_user_reg <= s1_reg.row_end;
            m_last_reg <= s1_reg.frame_end;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;
    assign m_tlast  = m_last_reg;

endmodule

// File: rtl/yuvds_ram.sv
`timescale 1ns / 1ps
// generic single-clock ram, one write port and one registered read port
// no dependencies

module yuvds_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule
